// ===== rtl/core/bis_pkg.sv =====
// types and codes shared by the batch integer sorter
// no dependencies
`timescale 1ns / 1ps

package bis_pkg;

   localparam int unsigned VALUE_W = 32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } bis_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      final_res;
      logic                      overflow;
   } bis_rsp_type;

   typedef struct packed {
      logic                      vld;
      logic signed [VALUE_W-1:0] value;
   } bis_slot_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_SHIFT
   } bis_cmd_type;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } bis_state_type;

endpackage

// ===== rtl/core/batch_integer_sorter.sv =====
// batch integer sorter top level: chain of insertion cells and output register
// depends on bis_pkg and bis_cell
`timescale 1ns / 1ps

// Sorts a batch of signed 32-bit values into ascending order.
// Input channel req_*: one element per item, req_payload.last closes the batch.
// Up to DEPTH elements are kept; later ones are dropped and every result of
// that batch then carries overflow.
// Result channel rsp_*: the kept elements in ascending order, final_res on the
// largest one.
// While loading, one item is taken each cycle: every cell compares the new
// element at once and the chain shifts right by one to insert it.
// After the last item the chain shifts left one cell per cycle into the output
// register while the receiver does not stall. req_ready is low while the chain
// drains; a new batch may start loading while the final result still waits.
// If the receiver stalls, the output register holds and the chain holds.
// Reset empties the chain and the output register and clears the drop flag.
module batch_integer_sorter #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bis_pkg::bis_req_type  req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bis_pkg::bis_rsp_type  rsp_payload
);

   bis_pkg::bis_slot_type  slots [DEPTH];
   logic                   gts   [DEPTH];
   bis_pkg::bis_cmd_type   cmd;
   bis_pkg::bis_state_type state_ff, state_in;
   logic                   drop_ff, drop_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bis_pkg::bis_rsp_type   rsp_ff, rsp_in;
   logic                   req_fire, full, shift;

   bis_pkg::bis_slot_type  empty_slot;
   assign empty_slot.vld   = 1'b0;
   assign empty_slot.value = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bis_pkg::bis_slot_type left_slot, right_slot;
      logic                  left_gt;
      if (i == 0) begin : g_first
         assign left_slot = empty_slot;
         assign left_gt   = 1'b0;
      end else begin : g_mid
         assign left_slot = slots[i-1];
         assign left_gt   = gts[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign right_slot = empty_slot;
      end else begin : g_inner
         assign right_slot = slots[i+1];
      end
      bis_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_value  (req_payload.value),
         .left_slot  (left_slot),
         .left_gt    (left_gt),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .gt         (gts[i])
      );
   end

   assign full      = slots[DEPTH-1].vld;
   assign req_ready = (state_ff == bis_pkg::ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign shift     = (state_ff == bis_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      drop_in      = drop_ff;
      cmd          = bis_pkg::CMD_HOLD;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         bis_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  cmd = bis_pkg::CMD_INSERT;
               end
               if (req_payload.last) begin
                  state_in = bis_pkg::ST_EMIT;
               end
            end
         end
         bis_pkg::ST_EMIT: begin
            if (shift) begin
               cmd                 = bis_pkg::CMD_SHIFT;
               rsp_valid_in        = 1'b1;
               rsp_in.sorted_value = slots[0].value;
               rsp_in.final_res    = !slots[1].vld;
               rsp_in.overflow     = drop_ff;
               if (!slots[1].vld) begin
                  state_in = bis_pkg::ST_LOAD;
                  drop_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = bis_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bis_pkg::ST_LOAD;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // first two cells of the chain stay sorted, with empties only behind full ones
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (slots[0].vld && slots[1].vld) |-> (slots[0].value <= slots[1].value))
      else $error("chain head out of order");

   a_packed: assert property (@(posedge clock) disable iff (reset)
      !slots[0].vld |-> !slots[1].vld)
      else $error("hole at chain head");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bis_pkg::ST_EMIT) |-> slots[0].vld)
      else $error("draining an empty chain");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("result item changed while stalled");

endmodule

// ===== rtl/core/bis_cell.sv =====
// one cell of the insertion chain: holds one element, inserts or shifts
// depends on bis_pkg
`timescale 1ns / 1ps

module bis_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bis_pkg::bis_cmd_type                   cmd,
   input  logic signed [bis_pkg::VALUE_W-1:0]     new_value,
   input  bis_pkg::bis_slot_type                  left_slot,
   input  logic                                   left_gt,
   input  bis_pkg::bis_slot_type                  right_slot,
   output bis_pkg::bis_slot_type                  slot,
   output logic                                   gt
);

   logic                                  vld_ff, vld_in;
   logic signed [bis_pkg::VALUE_W-1:0]    value_ff, value_in;

   // empty cells count as larger than anything
   assign gt = !vld_ff || (new_value < value_ff);

   always_comb begin
      vld_in   = vld_ff;
      value_in = value_ff;
      case (cmd)
         bis_pkg::CMD_INSERT: begin
            if (gt) begin
               if (left_gt) begin
                  vld_in   = left_slot.vld;
                  value_in = left_slot.value;
               end else begin
                  vld_in   = 1'b1;
                  value_in = new_value;
               end
            end
         end
         bis_pkg::CMD_SHIFT: begin
            vld_in   = right_slot.vld;
            value_in = right_slot.value;
         end
         default: begin
            vld_in   = vld_ff;
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign slot.vld   = vld_ff;
   assign slot.value = value_ff;

endmodule

// ===== tb/batch_integer_sorter_check.sv =====
// checker for the batch integer sorter: watches both channels, predicts the
// sorted output of each batch and compares every result item
// depends on bis_pkg
`timescale 1ns / 1ps

module batch_integer_sorter_check #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  bis_pkg::bis_req_type  req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bis_pkg::bis_rsp_type  rsp_payload,
   output int unsigned           fail_count,
   output int unsigned           pending
);

   import bis_pkg::*;

   logic signed [VALUE_W-1:0] batch_vals [DEPTH];
   int                        batch_len;
   logic                      batch_dropped;
   bis_rsp_type               sorted_due [$];

   always @(posedge clock) begin : watch
      bis_rsp_type               want;
      logic signed [VALUE_W-1:0] key;
      int                        j;
      if (reset) begin
         batch_len = 0;
         batch_dropped = 1'b0;
         sorted_due.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (batch_len < DEPTH) begin
               batch_vals[batch_len] = req_payload.value;
               batch_len++;
            end else begin
               batch_dropped = 1'b1;
            end
            if (req_payload.last) begin
               // ascending signed order, duplicates kept
               for (int i = 1; i < batch_len; i++) begin
                  key = batch_vals[i];
                  j = i;
                  while (j > 0 && key < batch_vals[j-1]) begin
                     batch_vals[j] = batch_vals[j-1];
                     j--;
                  end
                  batch_vals[j] = key;
               end
               for (int i = 0; i < batch_len; i++) begin
                  want.sorted_value = batch_vals[i];
                  want.final_res = (i == batch_len - 1);
                  want.overflow = batch_dropped;
                  sorted_due.push_back(want);
               end
               batch_len = 0;
               batch_dropped = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (sorted_due.size() == 0) begin
               $display("%0t: unexpected item, expected none, got value %0d final %0b overflow %0b",
                  $time, rsp_payload.sorted_value, rsp_payload.final_res,
                  rsp_payload.overflow);
               fail_count <= fail_count + 1;
            end else begin
               want = sorted_due.pop_front();
               if (rsp_payload.sorted_value !== want.sorted_value ||
                   rsp_payload.final_res !== want.final_res ||
                   rsp_payload.overflow !== want.overflow) begin
                  $display("%0t: mismatch, expected value %0d final %0b overflow %0b, got value %0d final %0b overflow %0b",
                     $time, want.sorted_value, want.final_res, want.overflow,
                     rsp_payload.sorted_value, rsp_payload.final_res,
                     rsp_payload.overflow);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= sorted_due.size();
   end

endmodule

// ===== tb/batch_integer_sorter_test.sv =====
// testbench top for the batch integer sorter: clock, reset, batch stimulus,
// random stalls on both channels, watchdog and verdict
// depends on bis_pkg, batch_integer_sorter and batch_integer_sorter_check
`timescale 1ns / 1ps

module batch_integer_sorter_test;

   import bis_pkg::*;

   localparam int DEPTH = 64;
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASE_ITEMS = 80;
   localparam int VALUE_MIN = 32'sh8000_0000;
   localparam int VALUE_MAX = 32'sh7fff_ffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   bis_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   bis_rsp_type rsp_payload;

   int unsigned send_idle = 30;
   int unsigned recv_idle = 55;
   int unsigned quiet_cycles = 0;
   int unsigned fail_count;
   int unsigned pending;

   always #5 clock = ~clock;

   batch_integer_sorter #(
      .DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   batch_integer_sorter_check #(
      .DEPTH(DEPTH)
   ) chk (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .fail_count(fail_count),
      .pending(pending)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_item(input bis_req_type item);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic int pick_value(input int mode);
      int v;
      case (mode)
         1: v = int'($urandom_range(0, 6)) - 3;
         2: begin
            case ($urandom_range(0, 4))
               0: v = VALUE_MIN;
               1: v = VALUE_MAX;
               2: v = 0;
               3: v = -1;
               default: v = 1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_batch(input int len, input int mode);
      bis_req_type item;
      for (int i = 0; i < len; i++) begin
         item.value = pick_value(mode);
         item.last = (i == len - 1);
         send_item(item);
      end
   endtask

   task automatic send_list(input int vals[$]);
      bis_req_type item;
      for (int i = 0; i < vals.size(); i++) begin
         item.value = vals[i];
         item.last = (i == vals.size() - 1);
         send_item(item);
      end
   endtask

   initial begin
      int dlist[$];
      int done;
      int len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // single element batches at the extremes
      dlist = '{VALUE_MAX};
      send_list(dlist);
      dlist = '{VALUE_MIN};
      send_list(dlist);
      // extremes mixed with duplicates
      dlist = '{0, -1, 1, VALUE_MIN, VALUE_MAX, VALUE_MIN, VALUE_MAX};
      send_list(dlist);
      dlist = '{5, 4, 3, 2, 1};
      send_list(dlist);
      dlist = '{-5, -5, -5};
      send_list(dlist);
      dlist = '{1, 2, 3, 4};
      send_list(dlist);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 30 : (phase == 1) ? 55 : 0;
         recv_idle = (phase == 0) ? 55 : (phase == 1) ? 30 : 0;
         done = 0;
         while (done < PHASE_ITEMS) begin
            // overflow batch first, then an exactly full one
            if (done == 0 && phase == 0) begin
               len = DEPTH + $urandom_range(1, 3);
            end else if (done == 0 && phase == 1) begin
               len = DEPTH;
            end else begin
               len = $urandom_range(1, 10);
            end
            send_batch(len, $urandom_range(0, 3));
            done += len;
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2 * DEPTH) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
